[sv/bbl_pkg.sv]
// Shared types, constants, microcode ROM and saturation helpers for the
// bass boost lowpass mix block. No dependencies.
package bbl_pkg;

  localparam int MAX_CHANS   = 32;
  localparam int CH_W        = 5;
  localparam int CNT_W       = 6;
  localparam int SAMPLE_BITS = 24;
  localparam int COEF_W      = 16;
  localparam int RAMP_W      = 17;
  localparam int BOOST_W     = 32;
  localparam int TGT_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 17;
  localparam int PC_W        = 3;
  localparam int MA_W        = SAMPLE_BITS + 1;
  localparam int MB_W        = BOOST_W + 2;
  localparam int PROD_W      = MA_W + MB_W;
  localparam int ACC_W       = PROD_W + 1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_COEFF = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_COEFF     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOOST_TARGET   = 2'd3;

  localparam logic [CNT_W-1:0]  RST_CHANNEL_COUNT  = 6'd2;
  localparam logic [COEF_W-1:0] RST_FEEDBACK_COEFF = 16'd63843;
  localparam logic [RAMP_W-1:0] RST_RAMP_COEFF     = 17'd27;
  localparam logic [TGT_W-1:0]  RST_BOOST_TARGET   = 16'd0;
  localparam logic [RAMP_W-1:0] RAMP_ONE           = 17'd65536;
  localparam logic [CNT_W-1:0]  CNT_MAX            = CNT_W'(MAX_CHANS);

  localparam logic signed [ACC_W-1:0] RND_Q16 = {{(ACC_W-16){1'b0}}, 1'b1, 15'b0};
  localparam logic signed [ACC_W-1:0] RND_Q29 = {{(ACC_W-29){1'b0}}, 1'b1, 28'b0};
  localparam logic signed [ACC_W-1:0] SMP_MAX =
    {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SMP_MIN = ~SMP_MAX;
  localparam logic signed [ACC_W-1:0] BST_MAX =
    {{(ACC_W-BOOST_W+1){1'b0}}, {(BOOST_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] BST_MIN = ~BST_MAX;

  localparam logic [1:0] MUL_NONE = 2'd0;
  localparam logic [1:0] MUL_LPF  = 2'd1;
  localparam logic [1:0] MUL_RAMP = 2'd2;
  localparam logic [1:0] MUL_MIX  = 2'd3;

  localparam logic [1:0] WB_NONE  = 2'd0;
  localparam logic [1:0] WB_LPF   = 2'd1;
  localparam logic [1:0] WB_BOOST = 2'd2;
  localparam logic [1:0] WB_EMIT  = 2'd3;

  localparam logic COND_NONE    = 1'b0;
  localparam logic COND_NOT_CH0 = 1'b1;

  localparam logic [PC_W-1:0] STEP_LPF_MUL   = 3'd0;
  localparam logic [PC_W-1:0] STEP_RAMP_MUL  = 3'd1;
  localparam logic [PC_W-1:0] STEP_BOOST_WB  = 3'd2;
  localparam logic [PC_W-1:0] STEP_MIX_MUL   = 3'd3;
  localparam logic [PC_W-1:0] STEP_EMIT      = 3'd4;

  typedef struct packed {
    logic [1:0]      mul_sel;
    logic [1:0]      wb;
    logic            cond;
    logic [PC_W-1:0] tgt;
    logic            last;
  } ctrl_t;

  localparam ctrl_t CTRL_NOP = '{mul_sel: MUL_NONE, wb: WB_NONE, cond: COND_NONE,
                                 tgt: STEP_LPF_MUL, last: 1'b0};

  function automatic ctrl_t rom(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w = CTRL_NOP;
    unique case (pc)
      STEP_LPF_MUL: begin
        w.mul_sel = MUL_LPF;
      end
      STEP_RAMP_MUL: begin
        w.mul_sel = MUL_RAMP;
        w.wb      = WB_LPF;
        w.cond    = COND_NOT_CH0;
        w.tgt     = STEP_MIX_MUL;
      end
      STEP_BOOST_WB: begin
        w.wb = WB_BOOST;
      end
      STEP_MIX_MUL: begin
        w.mul_sel = MUL_MIX;
      end
      STEP_EMIT: begin
        w.wb   = WB_EMIT;
        w.last = 1'b1;
      end
      default: begin
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

  function automatic sample_t sat_sample(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] c;
    c = v;
    if (v > SMP_MAX) c = SMP_MAX;
    else if (v < SMP_MIN) c = SMP_MIN;
    return c[SAMPLE_BITS-1:0];
  endfunction

  function automatic logic signed [BOOST_W-1:0] sat_boost(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] c;
    c = v;
    if (v > BST_MAX) c = BST_MAX;
    else if (v < BST_MIN) c = BST_MIN;
    return c[BOOST_W-1:0];
  endfunction

endpackage

[sv/bbl_in_if.sv]
// Input channel interface: valid/ready plus request type and sample.
// Depends on bbl_pkg.
interface bbl_in_if;
  import bbl_pkg::*;
  logic    valid;
  logic    ready;
  logic    req_type;
  sample_t sample_in;

  modport source (output valid, output req_type, output sample_in, input ready);
  modport sink   (input valid, input req_type, input sample_in, output ready);
endinterface

[sv/bbl_out_if.sv]
// Result channel interface: valid/ready plus boosted sample and channel.
// Depends on bbl_pkg.
interface bbl_out_if;
  import bbl_pkg::*;
  logic            valid;
  logic            ready;
  sample_t         sample_out;
  logic [CH_W-1:0] out_channel;

  modport source (output valid, output sample_out, output out_channel, input ready);
  modport sink   (input valid, input sample_out, input out_channel, output ready);
endinterface

[sv/bbl_seq.sv]
// Microcode sequencer: step counter, ROM fetch, conditional jump and stall.
// Depends on bbl_pkg.
module bbl_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start_i,
  input  logic           not_ch0_i,
  input  logic           out_blocked_i,
  output bbl_pkg::ctrl_t ctrl_o,
  output logic           busy_o,
  output logic           done_o
);
  import bbl_pkg::*;

  logic [PC_W-1:0] pc_r, pc_nxt;
  logic            busy_r, busy_nxt;
  ctrl_t           word;
  logic            stall, adv, taken;

  assign word  = rom(pc_r);
  assign stall = busy_r && (word.wb == WB_EMIT) && out_blocked_i;
  assign adv   = busy_r && !stall;
  assign taken = (word.cond == COND_NOT_CH0) && not_ch0_i;

  assign ctrl_o = adv ? word : CTRL_NOP;
  assign done_o = adv && word.last;
  assign busy_o = busy_r;

  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    if (start_i) begin
      busy_nxt = 1'b1;
      pc_nxt   = STEP_LPF_MUL;
    end else if (adv) begin
      if (word.last) begin
        busy_nxt = 1'b0;
        pc_nxt   = STEP_LPF_MUL;
      end else if (taken) begin
        pc_nxt = word.tgt;
      end else begin
        pc_nxt = pc_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= STEP_LPF_MUL;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
    end
  end
endmodule

[sv/bbl_dp.sv]
// Datapath: history store, shared multiplier, boost and lowpass registers,
// rounding and saturation. Driven by control words from bbl_seq. Depends on bbl_pkg.
module bbl_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bbl_pkg::ctrl_t             ctrl_i,
  input  logic                       load_i,
  input  logic                       clear_i,
  input  logic [bbl_pkg::CH_W-1:0]   ld_ch_i,
  input  logic [bbl_pkg::CH_W-1:0]   cur_ch_i,
  input  bbl_pkg::sample_t           sample_i,
  input  logic [bbl_pkg::COEF_W-1:0] feedback_i,
  input  logic [bbl_pkg::RAMP_W-1:0] ramp_i,
  input  logic [bbl_pkg::TGT_W-1:0]  target_i,
  output bbl_pkg::sample_t           y_o
);
  import bbl_pkg::*;

  sample_t                   hist_mem [MAX_CHANS];
  logic [MAX_CHANS-1:0]      hv_r;
  sample_t                   x_r, zraw_r, lpf_r, lpf_nxt, z;
  logic                      zv_r;
  logic signed [BOOST_W-1:0] boost_r, boost_nxt;
  logic signed [MA_W-1:0]    ma, dzx;
  logic signed [MB_W-1:0]    mb, diff;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [ACC_W-1:0]   prod_x, x_hi, x_lo, boost_x;
  logic signed [ACC_W-1:0]   lpf_sum, lpf_rnd, q16_rnd, q29_rnd, boost_sum, y_sum;

  assign z    = zv_r ? zraw_r : '0;
  assign dzx  = {z[SAMPLE_BITS-1], z} - {x_r[SAMPLE_BITS-1], x_r};
  assign diff = {{(MB_W-TGT_W-16){target_i[TGT_W-1]}}, target_i, 16'b0}
              - {{(MB_W-BOOST_W){boost_r[BOOST_W-1]}}, boost_r};

  always_comb begin
    unique case (ctrl_i.mul_sel)
      MUL_LPF: begin
        ma = dzx;
        mb = {{(MB_W-COEF_W){1'b0}}, feedback_i};
      end
      MUL_RAMP: begin
        ma = {{(MA_W-RAMP_W){1'b0}}, ramp_i};
        mb = diff;
      end
      MUL_MIX: begin
        ma = {lpf_r[SAMPLE_BITS-1], lpf_r};
        mb = {{(MB_W-BOOST_W){boost_r[BOOST_W-1]}}, boost_r};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod_nxt = ma * mb;

  assign prod_x  = {prod_r[PROD_W-1], prod_r};
  assign x_hi    = {{(ACC_W-SAMPLE_BITS-16){x_r[SAMPLE_BITS-1]}}, x_r, 16'b0};
  assign x_lo    = {{(ACC_W-SAMPLE_BITS){x_r[SAMPLE_BITS-1]}}, x_r};
  assign boost_x = {{(ACC_W-BOOST_W){boost_r[BOOST_W-1]}}, boost_r};

  assign lpf_sum   = x_hi + prod_x + RND_Q16;
  assign lpf_rnd   = lpf_sum >>> 16;
  assign lpf_nxt   = sat_sample(lpf_rnd);
  assign q16_rnd   = (prod_x + RND_Q16) >>> 16;
  assign boost_sum = boost_x + q16_rnd;
  assign boost_nxt = sat_boost(boost_sum);
  assign q29_rnd   = (prod_x + RND_Q29) >>> 29;
  assign y_sum     = x_lo + q29_rnd;
  assign y_o       = sat_sample(y_sum);

  always_ff @(posedge clk) begin
    if (load_i) begin
      zraw_r <= hist_mem[ld_ch_i];
    end
    if (ctrl_i.wb == WB_LPF) begin
      hist_mem[cur_ch_i] <= lpf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      x_r  <= sample_i;
      zv_r <= hv_r[ld_ch_i];
    end
    if (ctrl_i.mul_sel != MUL_NONE) begin
      prod_r <= prod_nxt;
    end
    if (ctrl_i.wb == WB_LPF) begin
      lpf_r <= lpf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r    <= '0;
      boost_r <= '0;
    end else begin
      if (clear_i) begin
        hv_r <= '0;
      end else if (ctrl_i.wb == WB_LPF) begin
        hv_r[cur_ch_i] <= 1'b1;
      end
      if (ctrl_i.wb == WB_BOOST) begin
        boost_r <= boost_nxt;
      end
    end
  end
endmodule

[sv/bass_boost_lowpass_mix.sv]
// Top level: configuration registers, channel counter, handshakes and
// result register around bbl_seq and bbl_dp. Depends on bbl_pkg and the channel interfaces.
//
//   port      | dir | beat content
//   in_bus    | in  | req_type, sample_in
//   out_bus   | out | sample_out, out_channel
//   cfg_*     | in  | cfg_we, cfg_index, cfg_wdata (write only)
//
// A sample beat runs lowpass, ramp and mix multiplies, then emits; channel 0 adds a boost
// write-back step, since the single shared multiplier is reused. A clear beat runs no steps.
// Reset is synchronous, active low; histories read as zero through per-channel valid bits.
// A new beat is taken while a result waits in the output register; the last step
// holds only when that register is still full.
module bass_boost_lowpass_mix (
  input  logic                          clk,
  input  logic                          rst_n,
  bbl_in_if.sink                        in_bus,
  bbl_out_if.source                     out_bus,
  input  logic                          cfg_we,
  input  logic [bbl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bbl_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bbl_pkg::*;

  logic [CNT_W-1:0]  cnt_r, cnt_eff;
  logic [COEF_W-1:0] fb_r;
  logic [RAMP_W-1:0] ramp_r, ramp_eff;
  logic [TGT_W-1:0]  tgt_r;
  logic [CH_W-1:0]   ch_r, chn, ch_next, cur_ch_r;
  logic [CNT_W-1:0]  ch_inc;
  logic              acc, ld, clr, busy, done, out_blocked;
  logic              out_valid_r;
  sample_t           out_sample_r, y;
  logic [CH_W-1:0]   out_ch_r;
  ctrl_t             ctrl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= RST_CHANNEL_COUNT;
      fb_r   <= RST_FEEDBACK_COEFF;
      ramp_r <= RST_RAMP_COEFF;
      tgt_r  <= RST_BOOST_TARGET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CHANNEL_COUNT:  cnt_r  <= cfg_wdata[CNT_W-1:0];
        CFG_FEEDBACK_COEFF: fb_r   <= cfg_wdata[COEF_W-1:0];
        CFG_RAMP_COEFF:     ramp_r <= cfg_wdata[RAMP_W-1:0];
        CFG_BOOST_TARGET:   tgt_r  <= cfg_wdata[TGT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cnt_eff  = (cnt_r == '0) ? CNT_W'(1) : ((cnt_r > CNT_MAX) ? CNT_MAX : cnt_r);
  assign ramp_eff = (ramp_r > RAMP_ONE) ? RAMP_ONE : ramp_r;
  assign chn      = ({1'b0, ch_r} >= cnt_eff) ? '0 : ch_r;
  assign ch_inc   = {1'b0, chn} + 1'b1;
  assign ch_next  = (ch_inc >= cnt_eff) ? '0 : ch_inc[CH_W-1:0];

  assign in_bus.ready = !busy || done;
  assign acc          = in_bus.valid && in_bus.ready;
  assign ld           = acc && !in_bus.req_type;
  assign clr          = acc && in_bus.req_type;
  assign out_blocked  = out_valid_r && !out_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r <= '0;
    end else if (clr) begin
      ch_r <= '0;
    end else if (ld) begin
      ch_r <= ch_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      cur_ch_r <= chn;
    end
    if (ctrl.wb == WB_EMIT) begin
      out_sample_r <= y;
      out_ch_r     <= cur_ch_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.wb == WB_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.sample_out  = out_sample_r;
  assign out_bus.out_channel = out_ch_r;

  bbl_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .start_i       (ld),
    .not_ch0_i     (cur_ch_r != '0),
    .out_blocked_i (out_blocked),
    .ctrl_o        (ctrl),
    .busy_o        (busy),
    .done_o        (done)
  );

  bbl_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl_i     (ctrl),
    .load_i     (ld),
    .clear_i    (clr),
    .ld_ch_i    (chn),
    .cur_ch_i   (cur_ch_r),
    .sample_i   (in_bus.sample_in),
    .feedback_i (fb_r),
    .ramp_i     (ramp_eff),
    .target_i   (tgt_r),
    .y_o        (y)
  );
endmodule

[tb/sv/tb_bass_boost_lowpass_mix.sv]
// Testbench for bass_boost_lowpass_mix: queue-fed driver, checking monitor and a
// cycle-free filter/boost predictor over several register settings and idle and stall mixes.
// Depends on bbl_pkg, bbl_in_if, bbl_out_if and the block itself.
module tb_bass_boost_lowpass_mix;
  timeunit 1ns;
  timeprecision 1ps;
  import bbl_pkg::*;

  localparam int     QUIET_LIMIT = 4000;
  localparam int     SETTLE      = 10;
  localparam longint SMP_HI      = 64'sd8388607;
  localparam longint SMP_LO      = -64'sd8388608;
  localparam longint BST_HI      = 64'sd2147483647;
  localparam longint BST_LO      = -64'sd2147483648;
  localparam longint UNITY       = 64'sd65536;

  typedef struct {
    logic    clr;
    sample_t smp;
  } audio_req_t;

  typedef struct {
    sample_t         sample;
    logic [CH_W-1:0] chan;
  } boosted_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bbl_in_if  in_bus ();
  bbl_out_if out_bus ();

  bass_boost_lowpass_mix i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .out_bus  (out_bus),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  audio_req_t audio_q[$];
  boosted_t   boosted_q[$];
  audio_req_t next_req;
  boosted_t   want;
  int         n_queued = 0;
  int         n_taken  = 0;
  int         n_errors = 0;
  int         idle_pct = 0;
  int         stall_pct = 0;
  int         quiet_cycles = 0;

  // predictor state and register copies
  sample_t            lp_hist[MAX_CHANS];
  logic signed [31:0] boost_q29;
  int unsigned        chan_ptr;
  logic [CNT_W-1:0]   m_count;
  logic [COEF_W-1:0]  m_fb;
  logic [RAMP_W-1:0]  m_ramp;
  logic signed [TGT_W-1:0] m_target;

  function automatic longint rnd_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic sample_t clamp24(longint v);
    if (v > SMP_HI) return sample_t'(SMP_HI);
    if (v < SMP_LO) return sample_t'(SMP_LO);
    return sample_t'(v);
  endfunction

  function automatic void boost_filter_step(logic clr, sample_t x);
    int unsigned cnt;
    int unsigned ch;
    longint      ramp;
    longint      diff;
    longint      nb;
    longint      a;
    sample_t     lpf;
    sample_t     y;
    cnt = (m_count == 0) ? 1 : ((m_count > MAX_CHANS) ? MAX_CHANS : m_count);
    if (clr) begin
      foreach (lp_hist[i]) lp_hist[i] = '0;
      chan_ptr = 0;
    end else begin
      if (chan_ptr >= cnt) chan_ptr = 0;
      ch = chan_ptr;
      if (ch == 0) begin
        ramp = (m_ramp > RAMP_ONE) ? UNITY : longint'(m_ramp);
        diff = longint'(m_target) * UNITY - longint'(boost_q29);
        nb   = longint'(boost_q29) + rnd_shift(ramp * diff, 16);
        if (nb > BST_HI) nb = BST_HI;
        if (nb < BST_LO) nb = BST_LO;
        boost_q29 = nb[31:0];
      end
      a   = longint'(m_fb);
      lpf = clamp24(rnd_shift((UNITY - a) * longint'(x) + a * longint'(lp_hist[ch]), 16));
      lp_hist[ch] = lpf;
      y = clamp24(longint'(x) + rnd_shift(longint'(boost_q29) * longint'(lpf), 29));
      boosted_q.push_back('{sample: y, chan: ch[CH_W-1:0]});
      chan_ptr = ch + 1;
      if (chan_ptr >= cnt) chan_ptr = 0;
    end
  endfunction

  function automatic void queue_req(logic clr, sample_t smp);
    audio_q.push_back('{clr: clr, smp: smp});
    n_queued++;
  endfunction

  task automatic write_regs(logic [CNT_W-1:0] cnt, logic [COEF_W-1:0] fb,
                            logic [RAMP_W-1:0] ramp, logic [TGT_W-1:0] tgt);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CHANNEL_COUNT;
    cfg_wdata <= {11'($urandom), cnt};
    @(posedge clk);
    cfg_index <= CFG_FEEDBACK_COEFF;
    cfg_wdata <= {1'($urandom), fb};
    @(posedge clk);
    cfg_index <= CFG_RAMP_COEFF;
    cfg_wdata <= ramp;
    @(posedge clk);
    cfg_index <= CFG_BOOST_TARGET;
    cfg_wdata <= {1'($urandom), tgt};
    @(posedge clk);
    cfg_we <= 1'b0;
    m_count  = cnt;
    m_fb     = fb;
    m_ramp   = ramp;
    m_target = tgt;
  endtask

  task automatic drain();
    while (n_taken != n_queued || boosted_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // driver: advance to the next beat once the current one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        boost_filter_step(in_bus.req_type, in_bus.sample_in);
        n_taken++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (audio_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          next_req = audio_q.pop_front();
          in_bus.valid     <= 1'b1;
          in_bus.req_type  <= next_req.clr;
          in_bus.sample_in <= next_req.smp;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result beat with the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (boosted_q.size() == 0) begin
          $error("unexpected beat: sample_out %0d out_channel %0d",
                 out_bus.sample_out, out_bus.out_channel);
          n_errors++;
        end else begin
          want = boosted_q.pop_front();
          if (out_bus.sample_out !== want.sample) begin
            $error("sample_out: expected %0d, actual %0d", want.sample, out_bus.sample_out);
            n_errors++;
          end
          if (out_bus.out_channel !== want.chan) begin
            $error("out_channel: expected %0d, actual %0d", want.chan, out_bus.out_channel);
            n_errors++;
          end
        end
      end
      out_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int               n_items;
    sample_t          smp;
    logic [CNT_W-1:0]  cnt;
    logic [COEF_W-1:0] fb;
    logic [RAMP_W-1:0] ramp;
    logic [TGT_W-1:0]  tgt;
    rst_n            = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.req_type  = 1'b0;
    in_bus.sample_in = '0;
    out_bus.ready    = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_CHANNEL_COUNT;
    cfg_wdata        = '0;
    foreach (lp_hist[i]) lp_hist[i] = '0;
    boost_q29 = '0;
    chan_ptr  = 0;
    m_count   = RST_CHANNEL_COUNT;
    m_fb      = RST_FEEDBACK_COEFF;
    m_ramp    = RST_RAMP_COEFF;
    m_target  = RST_BOOST_TARGET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: sample extremes and a clear between frames
    queue_req(1'b0, 24'sh7FFFFF);
    queue_req(1'b0, 24'sh800000);
    queue_req(1'b0, 24'sh000000);
    queue_req(1'b0, 24'shFFFFFF);
    queue_req(1'b1, sample_t'($urandom));
    queue_req(1'b0, 24'sh000001);
    queue_req(1'b0, 24'sh003039);
    drain();

    // zero channel count, open filter, instant full boost: saturate both ways
    write_regs(6'd0, 16'd0, RAMP_ONE, 16'h7FFF);
    queue_req(1'b0, 24'sh7FFFFF);
    queue_req(1'b0, 24'sh800000);
    queue_req(1'b0, 24'sh001000);
    queue_req(1'b0, -24'sh001000);
    drain();

    // count above the maximum, ramp above one, heaviest pole, lowest target
    write_regs(6'd40, 16'hFFFF, 17'h1FFFF, 16'h8000);
    repeat (4) queue_req(1'b0, sample_t'($urandom));
    queue_req(1'b1, sample_t'($urandom));
    repeat (2) queue_req(1'b0, sample_t'($urandom));
    drain();

    // three samples with a count of 4 from channel 2, then three with the count lowered to 2
    write_regs(6'd4, 16'd32768, 17'd0, 16'h1234);
    repeat (3) queue_req(1'b0, sample_t'($urandom));
    drain();
    write_regs(6'd2, 16'd32768, 17'd0, 16'h1234);
    repeat (3) queue_req(1'b0, sample_t'($urandom));
    drain();

    for (int p = 0; p < 12; p++) begin
      case ($urandom_range(9))
        0:       cnt = 6'd0;
        1:       cnt = 6'd32;
        2:       cnt = 6'($urandom_range(63, 33));
        3:       cnt = 6'd1;
        default: cnt = 6'($urandom_range(8, 1));
      endcase
      case ($urandom_range(5))
        0:       fb = 16'd0;
        1:       fb = 16'hFFFF;
        default: fb = 16'($urandom);
      endcase
      case ($urandom_range(6))
        0:       ramp = 17'd0;
        1:       ramp = RAMP_ONE;
        2:       ramp = 17'($urandom_range(131071, 65537));
        3:       ramp = 17'($urandom_range(2000));
        default: ramp = 17'($urandom_range(65536));
      endcase
      case ($urandom_range(5))
        0:       tgt = 16'h8000;
        1:       tgt = 16'h7FFF;
        default: tgt = 16'($urandom);
      endcase
      write_regs(cnt, fb, ramp, tgt);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 75; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 75; end
        default: begin idle_pct = 18; stall_pct = 18; end
      endcase
      n_items = $urandom_range(90, 50);
      repeat (n_items) begin
        case ($urandom_range(15))
          0:       smp = 24'sh7FFFFF;
          1:       smp = 24'sh800000;
          2, 3:    smp = sample_t'(int'($urandom_range(512)) - 256);
          default: smp = sample_t'($urandom);
        endcase
        if ($urandom_range(99) < 3) queue_req(1'b1, smp);
        else queue_req(1'b0, smp);
      end
      drain();
    end

    if (n_errors == 0 && boosted_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
sv/bbl_pkg.sv
sv/bbl_in_if.sv
sv/bbl_out_if.sv
sv/bbl_seq.sv
sv/bbl_dp.sv
sv/bass_boost_lowpass_mix.sv
tb/sv/tb_bass_boost_lowpass_mix.sv
